### src/agef_pkg.sv
// Package: shared types and constants for the audio gain and fade block.
`timescale 1ns / 1ps

package agef_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 24;
    localparam int Q_BITS    = 22;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd4194304;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TARGET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_scaled;
        logic signed [SAMPLE_W-1:0] right_scaled;
        logic                       fade_active;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              stereo;
        logic              fade_active;
    } t_gain_status;

endpackage

### src/agef_scale.sv
// Sample scaler: magnitude times Q2.22 gain, truncated toward zero, saturated to 16 bits.
`timescale 1ns / 1ps

module agef_scale (
    input  logic signed [agef_pkg::SAMPLE_W-1:0] i_sample,
    input  logic        [agef_pkg::GAIN_W-1:0]   i_gain,
    output logic signed [agef_pkg::SAMPLE_W-1:0] o_scaled
);

    localparam int MAG_W  = agef_pkg::SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + agef_pkg::GAIN_W;
    localparam int Q_W    = PROD_W - agef_pkg::Q_BITS;

    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [MAG_W-1:0]  q_sat;

    always_comb begin
        neg  = i_sample[agef_pkg::SAMPLE_W-1];
        mag  = neg ? MAG_W'(-{1'b1, i_sample}) : {1'b0, i_sample};
        prod = PROD_W'(mag) * PROD_W'(i_gain);
        q    = prod[PROD_W-1:agef_pkg::Q_BITS];
        if (neg) begin
            // negative side reaches one step further
            q_sat = (q > Q_W'(32768)) ? MAG_W'(32768) : q[MAG_W-1:0];
            o_scaled = agef_pkg::SAMPLE_W'(-q_sat);
        end else begin
            q_sat = (q > Q_W'(32767)) ? MAG_W'(32767) : q[MAG_W-1:0];
            o_scaled = q_sat[agef_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

### src/agef_gain.sv
// Gain state: configuration registers, running gain and the exponential fade step.
`timescale 1ns / 1ps

module agef_gain (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [agef_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [agef_pkg::GAIN_W-1:0]           i_cfg_data,
    input  logic                                  i_advance,
    output agef_pkg::t_gain_status                o_status
);

    localparam int GW     = agef_pkg::GAIN_W;
    localparam int PROD_W = 2 * GW;
    localparam int Q_W    = PROD_W - agef_pkg::Q_BITS;

    logic [GW-1:0] r_gain,   n_gain;
    logic [GW-1:0] r_factor, n_factor;
    logic [GW-1:0] r_target, n_target;
    logic          r_stereo, n_stereo;
    logic          r_fading, n_fading;

    logic              fade_end;
    logic              fading_after;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [GW-1:0]     gain_step;

    always_comb begin
        fade_end = r_fading &&
                   (((r_factor < agef_pkg::GAIN_ONE) && (r_gain <= r_target)) ||
                    ((r_factor > agef_pkg::GAIN_ONE) && (r_gain >= r_target)));
        fading_after = r_fading && !fade_end;
        prod = PROD_W'(r_gain) * PROD_W'(r_factor);
        q    = prod[PROD_W-1:agef_pkg::Q_BITS];
        gain_step = (|q[Q_W-1:GW]) ? agef_pkg::GAIN_MAX : q[GW-1:0];
    end

    always_comb begin
        n_gain   = r_gain;
        n_factor = r_factor;
        n_target = r_target;
        n_stereo = r_stereo;
        n_fading = r_fading;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                agef_pkg::CFG_START_LEVEL: n_gain = i_cfg_data;
                agef_pkg::CFG_FADE_FACTOR: begin
                    n_factor = i_cfg_data;
                    n_fading = (i_cfg_data != agef_pkg::GAIN_ONE);
                end
                agef_pkg::CFG_FADE_TARGET: n_target = i_cfg_data;
                agef_pkg::CFG_STEREO:      n_stereo = i_cfg_data[0];
                default:                   n_stereo = r_stereo;
            endcase
        end else if (i_advance) begin
            n_fading = fading_after;
            if (fade_end) begin
                n_gain = r_target;
            end else if (r_fading) begin
                n_gain = gain_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= agef_pkg::GAIN_ONE;
            r_factor <= agef_pkg::GAIN_ONE;
            r_target <= agef_pkg::GAIN_ONE;
            r_stereo <= 1'b1;
            r_fading <= 1'b0;
        end else begin
            r_gain   <= n_gain;
            r_factor <= n_factor;
            r_target <= n_target;
            r_stereo <= n_stereo;
            r_fading <= n_fading;
        end
    end

    assign o_status.gain        = r_gain;
    assign o_status.stereo      = r_stereo;
    assign o_status.fade_active = fading_after;

    a_fade_stays_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fading && !(i_cfg_we && (i_cfg_index == agef_pkg::CFG_FADE_FACTOR)))
        |=> !r_fading)
        else $error("fade restarted without a factor write");

    a_start_loads_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == agef_pkg::CFG_START_LEVEL))
        |=> (r_gain == $past(i_cfg_data)))
        else $error("start level write did not load the gain");

endmodule

### src/audio_gain_exponential_fade.sv
// Top level: audio gain stage with exponential fade, input and result registers.
// A frame is held in the input register, then in the result register once that is free.
// Throughput: one frame per cycle; the gain recurrence is one 24x24 multiply per cycle.
// The input stalls only while both registers hold a frame and the output is stalled.
// Reset (synchronous, i_rst_n low): pipeline empty, gain and factor and target 1.0,
// stereo on, no fade running.
`timescale 1ns / 1ps

module audio_gain_exponential_fade (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [agef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [agef_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  agef_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output agef_pkg::t_out_item            o_out_data
);

    agef_pkg::t_gain_status status;

    logic                                 r_s1_valid;
    logic signed [agef_pkg::SAMPLE_W-1:0] r_s1_left;
    logic signed [agef_pkg::SAMPLE_W-1:0] r_s1_right;
    logic        [agef_pkg::GAIN_W-1:0]   r_s1_gain;
    logic                                 r_s1_stereo;
    logic                                 r_s1_fade;

    logic                r_out_valid;
    agef_pkg::t_out_item r_out;

    logic signed [agef_pkg::SAMPLE_W-1:0] left_scaled;
    logic signed [agef_pkg::SAMPLE_W-1:0] right_scaled;

    logic out_free;
    logic in_xfer;
    logic s1_move;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign s1_move    = r_s1_valid && out_free;

    agef_gain u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_advance  (in_xfer),
        .o_status   (status)
    );

    agef_scale u_scale_left (
        .i_sample(r_s1_left),
        .i_gain  (r_s1_gain),
        .o_scaled(left_scaled)
    );

    agef_scale u_scale_right (
        .i_sample(r_s1_right),
        .i_gain  (r_s1_gain),
        .o_scaled(right_scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_left   <= i_in_data.left_sample;
            r_s1_right  <= i_in_data.right_sample;
            r_s1_gain   <= status.gain;
            r_s1_stereo <= status.stereo;
            r_s1_fade   <= status.fade_active;
        end
        if (s1_move) begin
            r_out.left_scaled  <= left_scaled;
            r_out.right_scaled <= r_s1_stereo ? right_scaled : '0;
            r_out.fade_active  <= r_s1_fade;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input not stalled with both stages full");

    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !r_s1_stereo) |=> (o_out_data.right_scaled == '0))
        else $error("mono transfer produced a non-zero right sample");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result lost");

endmodule

### bench/testbench.sv
// Testbench for the audio gain and fade block: directed table, random frames, self-checking.
`timescale 1ns / 1ps

module testbench;

    localparam int DIRECTED_ROWS  = 43;
    localparam int RANDOM_FRAMES  = 1000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic {ROW_CFG, ROW_FRAME} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [agef_pkg::CFG_IDX_W-1:0] index;
        logic [agef_pkg::GAIN_W-1:0]    value;
        agef_pkg::t_in_item             frame;
        logic                           typed;
        agef_pkg::t_out_item            want;
    } t_plan_row;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [agef_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [agef_pkg::GAIN_W-1:0]    cfg_data = '0;
    logic                           in_valid = 1'b0;
    agef_pkg::t_in_item             in_data = '0;
    logic                           out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    agef_pkg::t_out_item            o_out_data;

    // gain model state and register copies
    logic [agef_pkg::GAIN_W-1:0] gain_now   = agef_pkg::GAIN_ONE;
    logic                        fade_on    = 1'b0;
    logic [agef_pkg::GAIN_W-1:0] reg_factor = agef_pkg::GAIN_ONE;
    logic [agef_pkg::GAIN_W-1:0] reg_target = agef_pkg::GAIN_ONE;
    logic                        reg_stereo = 1'b1;

    agef_pkg::t_out_item expected_frames [$];
    t_plan_row directed_plan [DIRECTED_ROWS];

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit hold_request = 1'b0;

    int fails = 0;
    int frames_sent = 0;
    int directed_frames = 0;
    int results_checked = 0;
    int settings_written = 0;
    int fades_ended = 0;
    int samples_clipped = 0;
    int quiet_cycles = 0;

    audio_gain_exponential_fade dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [agef_pkg::SAMPLE_W-1:0] apply_gain(
        logic signed [agef_pkg::SAMPLE_W-1:0] s, logic [agef_pkg::GAIN_W-1:0] g);
        logic [16:0] mag;
        logic [40:0] prod;
        logic [18:0] q;
        mag  = s[15] ? 17'h1_0000 - {1'b0, s} : {1'b0, s};
        prod = mag * g;
        q    = prod[40:22];
        if (s[15]) begin
            if (q > 19'd32768) begin
                q = 19'd32768;
                samples_clipped++;
            end
            return 16'(19'h1_0000 - q);
        end
        if (q > 19'd32767) begin
            q = 19'd32767;
            samples_clipped++;
        end
        return q[15:0];
    endfunction

    function automatic agef_pkg::t_out_item predict_frame(agef_pkg::t_in_item f);
        agef_pkg::t_out_item r;
        logic [47:0]         g48;
        r.left_scaled  = apply_gain(f.left_sample, gain_now);
        r.right_scaled = reg_stereo ? apply_gain(f.right_sample, gain_now) : '0;
        if (fade_on && ((reg_factor < agef_pkg::GAIN_ONE && gain_now <= reg_target) ||
                        (reg_factor > agef_pkg::GAIN_ONE && gain_now >= reg_target))) begin
            gain_now = reg_target;
            fade_on  = 1'b0;
            fades_ended++;
        end
        if (fade_on) begin
            g48      = gain_now * reg_factor;
            g48      = g48 >> agef_pkg::Q_BITS;
            gain_now = (g48 > agef_pkg::GAIN_MAX) ? agef_pkg::GAIN_MAX
                                                  : g48[agef_pkg::GAIN_W-1:0];
        end
        r.fade_active = fade_on;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [agef_pkg::CFG_IDX_W-1:0] idx,
                                          logic [agef_pkg::GAIN_W-1:0] v);
        t_plan_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.value = v;
        return r;
    endfunction

    function automatic t_plan_row frame_row(int l, int rt);
        t_plan_row r;
        r                    = '0;
        r.kind               = ROW_FRAME;
        r.frame.left_sample  = 16'(l);
        r.frame.right_sample = 16'(rt);
        return r;
    endfunction

    // expected value readable straight off the input, fade idle
    function automatic t_plan_row checked_row(int l, int rt, int wl, int wr);
        t_plan_row r;
        r                   = frame_row(l, rt);
        r.typed             = 1'b1;
        r.want.left_scaled  = 16'(wl);
        r.want.right_scaled = 16'(wr);
        r.want.fade_active  = 1'b0;
        return r;
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [agef_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 32) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [agef_pkg::GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return agef_pkg::GAIN_MAX;
            2: return agef_pkg::GAIN_ONE;
            default: return 24'($urandom_range(0, 24'h80_0000));
        endcase
    endfunction

    task automatic cfg_write(input logic [agef_pkg::CFG_IDX_W-1:0] idx,
                             input logic [agef_pkg::GAIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            agef_pkg::CFG_START_LEVEL: gain_now = v;
            agef_pkg::CFG_FADE_FACTOR: begin
                reg_factor = v;
                fade_on    = (v != agef_pkg::GAIN_ONE);
            end
            agef_pkg::CFG_FADE_TARGET: reg_target = v;
            agef_pkg::CFG_STEREO:      reg_stereo = v[0];
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic send_frame(input agef_pkg::t_in_item f, input bit typed,
                              input agef_pkg::t_out_item want);
        int gap;
        agef_pkg::t_out_item predicted;
        gap = pick_gap(tx_gaps);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        predicted = predict_frame(f);
        expected_frames.push_back(typed ? want : predicted);
        frames_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic pick_settings();
        logic [agef_pkg::GAIN_W-1:0] lvl;
        logic [agef_pkg::GAIN_W-1:0] fac;
        logic [agef_pkg::GAIN_W-1:0] tgt;
        lvl = rand_gain();
        tgt = rand_gain();
        case ($urandom_range(0, 4))
            0: fac = agef_pkg::GAIN_ONE;
            1: fac = agef_pkg::GAIN_ONE - 24'($urandom_range(1, 300000));
            2: fac = agef_pkg::GAIN_ONE + 24'($urandom_range(1, 600000));
            default: fac = 24'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0)
            cfg_write(agef_pkg::CFG_STEREO, {23'($urandom), 1'($urandom_range(0, 4) != 0)});
        if ($urandom_range(0, 3) != 0)
            cfg_write(agef_pkg::CFG_FADE_TARGET, tgt);
        if ($urandom_range(0, 3) != 0)
            cfg_write(agef_pkg::CFG_FADE_FACTOR, fac);
        cfg_write(agef_pkg::CFG_START_LEVEL, lvl);
    endtask

    // receiver: random stall pattern, plus one long hold-off on request
    initial begin : receiver
        int len;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                len = HOLD_CYCLES;
            end else begin
                len = pick_gap(rx_gaps);
            end
            if (len > 0) begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        agef_pkg::t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_frames.size() == 0) begin
                $error("result transfer with no frame outstanding: %h", o_out_data);
                fails++;
            end else begin
                want = expected_frames.pop_front();
                results_checked++;
                if (o_out_data.left_scaled !== want.left_scaled) begin
                    $error("left_scaled: expected %0d, got %0d",
                           want.left_scaled, o_out_data.left_scaled);
                    fails++;
                end
                if (o_out_data.right_scaled !== want.right_scaled) begin
                    $error("right_scaled: expected %0d, got %0d",
                           want.right_scaled, o_out_data.right_scaled);
                    fails++;
                end
                if (o_out_data.fade_active !== want.fade_active) begin
                    $error("fade_active: expected %0d, got %0d",
                           want.fade_active, o_out_data.fade_active);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_frames.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int                 phase;
        int                 n;
        int                 random_frames;
        agef_pkg::t_in_item f;
        phase         = 0;
        random_frames = 0;
        directed_plan = '{
            checked_row(32767, -32768, 32767, -32768),
            checked_row(0, 0, 0, 0),
            checked_row(-1, 1, -1, 1),
            checked_row(12345, -12345, 12345, -12345),
            cfg_row(agef_pkg::CFG_STEREO, 24'd0),
            checked_row(1000, -1000, 1000, 0),
            cfg_row(agef_pkg::CFG_STEREO, 24'd1),
            cfg_row(agef_pkg::CFG_START_LEVEL, agef_pkg::GAIN_MAX),
            checked_row(32767, -32768, 32767, -32768),
            frame_row(100, -100),
            cfg_row(agef_pkg::CFG_START_LEVEL, 24'd0),
            checked_row(32767, -32768, 0, 0),
            // falling fade: halve per frame down to a quarter
            cfg_row(agef_pkg::CFG_FADE_TARGET, 24'd1048576),
            cfg_row(agef_pkg::CFG_FADE_FACTOR, 24'd2097152),
            cfg_row(agef_pkg::CFG_START_LEVEL, agef_pkg::GAIN_ONE),
            frame_row(20000, -20000),
            frame_row(20000, -20000),
            frame_row(-32768, 32767),
            frame_row(20000, -20000),
            // rising fade landing exactly on its target
            cfg_row(agef_pkg::CFG_FADE_TARGET, 24'd8388608),
            cfg_row(agef_pkg::CFG_FADE_FACTOR, 24'd8388608),
            cfg_row(agef_pkg::CFG_START_LEVEL, 24'd1048576),
            frame_row(30000, -30000),
            frame_row(30000, -30000),
            frame_row(30000, -30000),
            frame_row(30000, -30000),
            // rising fade stuck at zero gain
            cfg_row(agef_pkg::CFG_FADE_TARGET, agef_pkg::GAIN_ONE),
            cfg_row(agef_pkg::CFG_FADE_FACTOR, 24'd6291456),
            cfg_row(agef_pkg::CFG_START_LEVEL, 24'd0),
            frame_row(-32768, 32767),
            frame_row(-32768, 32767),
            // gain recurrence clipping at full scale
            cfg_row(agef_pkg::CFG_FADE_TARGET, agef_pkg::GAIN_MAX),
            cfg_row(agef_pkg::CFG_FADE_FACTOR, agef_pkg::GAIN_MAX),
            cfg_row(agef_pkg::CFG_START_LEVEL, 24'd8388608),
            frame_row(-32768, 32767),
            frame_row(1, -1),
            // zero factor, zero target
            cfg_row(agef_pkg::CFG_FADE_TARGET, 24'd0),
            cfg_row(agef_pkg::CFG_FADE_FACTOR, 24'd0),
            cfg_row(agef_pkg::CFG_START_LEVEL, agef_pkg::GAIN_ONE),
            frame_row(777, -777),
            frame_row(777, -777),
            cfg_row(agef_pkg::CFG_FADE_FACTOR, agef_pkg::GAIN_ONE),
            frame_row(-4321, 4321)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(directed_plan[i].index, directed_plan[i].value);
            end else begin
                send_frame(directed_plan[i].frame, directed_plan[i].typed,
                           directed_plan[i].want);
                directed_frames++;
            end
        end

        while (random_frames < RANDOM_FRAMES) begin
            wait_idle();
            pick_settings();
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            n = $urandom_range(10, 60);
            if (phase == 1) begin
                // back-to-back frames against a long output hold-off
                tx_gaps      = 1'b0;
                hold_request = 1'b1;
                while (hold_request) @(posedge clk);
                n = 60;
            end
            repeat (n) begin
                f.left_sample  = rand_sample();
                f.right_sample = rand_sample();
                send_frame(f, 1'b0, '0);
                random_frames++;
            end
            phase++;
        end

        wait_idle();
        $display("%0d frames (%0d directed), %0d results compared, %0d register writes",
                 frames_sent, directed_frames, results_checked, settings_written);
        $display("%0d fades reached their target, %0d samples clipped to 16 bits",
                 fades_ended, samples_clipped);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
src/agef_pkg.sv
src/agef_scale.sv
src/agef_gain.sv
src/audio_gain_exponential_fade.sv
bench/testbench.sv
